### hw/rtl/xbm_pkg.sv
// Shared types, constants and helper functions for the bitmap bits stream decoder.
// No dependencies; imported by every module of the block.
package xbm_pkg;

    // Widths of the fixed fields and counters
    localparam int CHAR_W  = 8;
    localparam int SIDE_W  = 12;
    localparam int ACC_W   = 16;
    localparam int LP_W    = 10;
    localparam int ROW_W   = 12;
    localparam int CIDX_W  = 2;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_WORD_FORMAT  = 2'd2
    } cfg_index_t;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // Word format codes
    localparam logic FMT_BYTE  = 1'b0;
    localparam logic FMT_SHORT = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF     = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h66;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2c;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7d;
    localparam logic [CHAR_W-1:0] CH_LF_NL  = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;

    // One result item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       status;
        logic       last_of_image;
    } result_t;

    // Results produced by one input item
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } result_pair_t;

    // Hex digit decode
    typedef struct packed {
        logic       valid;
        logic [3:0] nibble;
    } hex_t;

    // Line/row counters after one advance
    typedef struct packed {
        logic [LP_W-1:0]  lp;
        logic [ROW_W-1:0] row;
        logic             last;
    } adv_t;

    function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
        hex_t h;
        h.valid  = 1'b1;
        h.nibble = 4'd0;
        if (c >= CH_0 && c <= CH_9) begin
            h.nibble = 4'(c - CH_0);
        end else if (c >= CH_UA && c <= CH_UF) begin
            h.nibble = 4'(c - CH_UA + 8'd10);
        end else if (c >= CH_LA && c <= CH_LF) begin
            h.nibble = 4'(c - CH_LA + 8'd10);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_delim(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_RBRACE) ||
               (c == CH_LF_NL) || (c == CH_TAB);
    endfunction

    // Count byte slots on the line; wrap to the next row at the line bound
    function automatic adv_t line_advance(input logic [LP_W-1:0]   lp,
                                          input logic [ROW_W-1:0]  row,
                                          input logic [1:0]        slots,
                                          input logic [LP_W-1:0]   bpl,
                                          input logic [SIDE_W-1:0] height);
        adv_t           a;
        logic [LP_W:0]  sum;
        logic [ROW_W:0] row_inc;
        sum     = {1'b0, lp} + {{(LP_W-1){1'b0}}, slots};
        row_inc = {1'b0, row} + {{ROW_W{1'b0}}, 1'b1};
        if (sum >= {1'b0, bpl}) begin
            a.lp   = '0;
            a.row  = row_inc[ROW_W-1:0];
            a.last = (row_inc >= {1'b0, height});
        end else begin
            a.lp   = sum[LP_W-1:0];
            a.row  = row;
            a.last = 1'b0;
        end
        return a;
    endfunction

endpackage

### hw/rtl/xbm_core.sv
// Decoder core: configuration registers, parse state and per-item result logic.
// Depends on xbm_pkg.
module xbm_core
    import xbm_pkg::*;
#(
    parameter int MAX_SIDE = 4095
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [SIDE_W-1:0]   cfg_data,
    input  logic                accept,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic                end_of_stream,
    output result_pair_t        results
);

    logic [SIDE_W-1:0] width_reg;
    logic [SIDE_W-1:0] height_reg;
    logic              format_reg;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              seen_reg, seen_next;
    logic [LP_W-1:0]   lp_reg, lp_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              fin_reg, fin_next;

    hex_t              hd;
    logic              bad_dims;
    logic              pad;
    logic [LP_W-1:0]   bpl;
    logic [LP_W:0]     lp_plus2;
    logic              two_slot;
    adv_t              adv1;
    adv_t              adv2;

    // Hold configuration; writes never touch the parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            format_reg <= FMT_BYTE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                CFG_WORD_FORMAT:  format_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Line geometry and slot counting
    always_comb
    begin
        bad_dims = (width_reg == '0) || (height_reg == '0) ||
                   ({20'd0, width_reg} > 32'(MAX_SIDE)) ||
                   ({20'd0, height_reg} > 32'(MAX_SIDE));
        pad      = (format_reg == FMT_SHORT) && (width_reg[3:0] != 4'd0) &&
                   (width_reg[3:0] < 4'd9);
        bpl      = LP_W'(({1'b0, width_reg} + 13'd7) >> 3) + {{(LP_W-1){1'b0}}, pad};
        lp_plus2 = {1'b0, lp_reg} + 11'd2;
        two_slot = pad && (lp_plus2 >= {1'b0, bpl});
        hd       = hex_decode(char_code);
        adv1     = line_advance(lp_reg, row_reg, two_slot ? 2'd2 : 2'd1, bpl, height_reg);
        adv2     = line_advance(adv1.lp, adv1.row, 2'd1, bpl, height_reg);
    end

    // Next state and results for the accepted item
    always_comb
    begin
        acc_next  = acc_reg;
        seen_next = seen_reg;
        lp_next   = lp_reg;
        row_next  = row_reg;
        fin_next  = fin_reg;
        results   = '0;
        if (accept && !fin_reg)
        begin
            if (bad_dims || end_of_stream)
            begin
                fin_next      = 1'b1;
                results.count = 2'd1;
                results.r0    = '{data_byte: 8'd0, status: STATUS_INVALID, last_of_image: 1'b1};
            end
            else if (hd.valid)
            begin
                acc_next  = {acc_reg[ACC_W-5:0], hd.nibble};
                seen_next = 1'b1;
            end
            else if (is_delim(char_code) && seen_reg)
            begin
                acc_next      = '0;
                seen_next     = 1'b0;
                lp_next       = adv1.lp;
                row_next      = adv1.row;
                fin_next      = adv1.last;
                results.count = 2'd1;
                results.r0    = '{data_byte: acc_reg[7:0], status: STATUS_OK,
                                  last_of_image: adv1.last};
                // Emit the high byte unless the line or image closed on the low byte
                if ((format_reg == FMT_SHORT) && !two_slot && !adv1.last)
                begin
                    lp_next       = adv2.lp;
                    row_next      = adv2.row;
                    fin_next      = adv2.last;
                    results.count = 2'd2;
                    results.r1    = '{data_byte: acc_reg[15:8], status: STATUS_OK,
                                      last_of_image: adv2.last};
                end
            end
        end
    end

    // Advance parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            seen_reg <= 1'b0;
            lp_reg   <= '0;
            row_reg  <= '0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            seen_reg <= seen_next;
            lp_reg   <= lp_next;
            row_reg  <= row_next;
            fin_reg  <= fin_next;
        end
    end

endmodule

### hw/rtl/xbm_res_fifo.sv
// Four-entry result queue taking up to two result items per cycle, giving one per cycle while not stalled.
// Depends on xbm_pkg.
module xbm_res_fifo
    import xbm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  result_pair_t push,
    output logic         full2,
    output logic         out_valid,
    input  logic         out_stall,
    output result_t      out_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    assign out_valid    = (count_reg != '0);
    assign out_item     = mem[rd_ptr_reg];
    assign full2        = (count_reg > CNT_W'(DEPTH - 2));
    assign pop          = out_valid && !out_stall;
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the low-byte item, then the high-byte item behind it
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.r1;
        end
    end

endmodule

### hw/rtl/xbm_bits_stream_decoder_unit.sv
// Top level of the bitmap bits stream decoder: joins the decoder core and result queue.
// Depends on xbm_pkg, xbm_core and xbm_res_fifo.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one text character per item
//   (char_code) or an end marker (end_of_stream). Output channel
//   (out_valid/out_stall) carries decoded bytes with status and
//   last_of_image. Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   sets image_width, image_height and word_format; cfg_ready is always high.
//   Write configuration only while the block is idle.
//   Throughput: one character per cycle while in_stall is low. A delimiter in sixteen-bit format
//   can give two bytes, which leave the output one per cycle while out_stall is low.
//   Result items are formed combinationally by the core and registered in
//   the result queue, which hands them to the output in order.
//   The four-entry result queue sets the input side: in_stall rises when
//   fewer than two free entries remain, so a stalled receiver backs up the
//   input once three or four items wait.
//   Reset clears the registers, the parse state and the queue; a new image
//   starts only after reset. After the last byte or an error result the
//   block gives no more output until reset.
module xbm_bits_stream_decoder_unit
    import xbm_pkg::*;
#(
    parameter int MAX_SIDE = 4095
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic                end_of_stream,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          data_byte,
    output logic                status,
    output logic                last_of_image,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [SIDE_W-1:0]   cfg_data
);

    result_pair_t results;
    result_t      out_item;
    logic         full2;
    logic         accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = full2;
    assign accept    = in_valid && !full2;

    // Parse characters and form result items
    xbm_core #(
        .MAX_SIDE(MAX_SIDE)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .char_code     (char_code),
        .end_of_stream (end_of_stream),
        .results       (results)
    );

    // Queue result items toward the receiver
    xbm_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (results),
        .full2     (full2),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    assign data_byte     = out_item.data_byte;
    assign status        = out_item.status;
    assign last_of_image = out_item.last_of_image;

endmodule

### hw/rtl/xbm_checker.sv
// Port-level checks for the bitmap bits stream decoder, bound to the top level.
// Depends on xbm_pkg.
module xbm_checker
    import xbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] data_byte,
    input  logic       status,
    input  logic       last_of_image
);

    // Hold a stalled output item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_byte) &&
        $stable(status) && $stable(last_of_image))
        else $error("output item changed while stalled");

    // An error result is a zero byte that closes the image
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_INVALID) |-> last_of_image && (data_byte == 8'd0))
        else $error("error result malformed");

    // Nothing follows the closing item of an image
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_of_image |=> !out_valid)
        else $error("output after last item of image");

endmodule

bind xbm_bits_stream_decoder_unit xbm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .data_byte     (data_byte),
    .status        (status),
    .last_of_image (last_of_image)
);
